FILE: src/mtep_pkg.sv
// Shared types and constants for the track event parser.
// Holds the result record, the event kind codes and the queue depth.
// No dependencies.
`timescale 1ns / 1ps

package mtep_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] KIND_NOTE_OFF  = 4'd0;
    localparam logic [3:0] KIND_NOTE_ON   = 4'd1;
    localparam logic [3:0] KIND_POLY      = 4'd2;
    localparam logic [3:0] KIND_CONTROL   = 4'd3;
    localparam logic [3:0] KIND_PROGRAM   = 4'd4;
    localparam logic [3:0] KIND_CHAN_PRES = 4'd5;
    localparam logic [3:0] KIND_BEND      = 4'd6;
    localparam logic [3:0] KIND_META      = 4'd7;
    localparam logic [3:0] KIND_SYSEX     = 4'd8;
    localparam logic [3:0] KIND_PAYLOAD   = 4'd9;

    localparam logic [7:0] ST_META       = 8'hFF;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] META_EOT      = 8'h2F;
    localparam logic [3:0] HI_CHAN_FIRST = 4'h8;
    localparam logic [3:0] HI_CHAN_LAST  = 4'hE;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_CHAN_PRES  = 4'hD;
    localparam logic [3:0] HI_BEND       = 4'hE;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  channel;
        logic [27:0] delta_time;
        logic [7:0]  first_value;
        logic [13:0] second_value;
        logic [27:0] payload_length;
        logic        last_payload;
        logic        end_of_track;
    } result_t;

endpackage

FILE: src/mtep_front.sv
// Front end of the track event parser: byte classification and event decode.
// Emits at most one result record per accepted byte. Uses mtep_pkg.
`timescale 1ns / 1ps

module mtep_front
    import mtep_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_fire,
    input  logic [7:0] in_byte,
    output logic    res_valid,
    output result_t res
);

    localparam logic [2:0] PH_HDR     = 3'd0;
    localparam logic [2:0] PH_DELTA   = 3'd1;
    localparam logic [2:0] PH_STATUS  = 3'd2;
    localparam logic [2:0] PH_DATA1   = 3'd3;
    localparam logic [2:0] PH_DATA2   = 3'd4;
    localparam logic [2:0] PH_MTYPE   = 3'd5;
    localparam logic [2:0] PH_LEN     = 3'd6;
    localparam logic [2:0] PH_PAYLOAD = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  run_status_reg, run_status_next;
    logic [7:0]  cur_status_reg, cur_status_next;
    logic [27:0] delta_reg, delta_next;
    logic [7:0]  meta_kind_reg, meta_kind_next;
    logic [27:0] len_reg, len_next;
    logic [27:0] left_reg, left_next;
    logic [7:0]  held_reg, held_next;

    function automatic logic is_chan(input logic [7:0] st);
        return (st[7:4] >= HI_CHAN_FIRST) && (st[7:4] <= HI_CHAN_LAST);
    endfunction

    always_comb begin
        logic        do_first;
        logic [7:0]  fd_st;
        logic [27:0] len_new;
        logic [27:0] left_new;
        logic        is_meta;
        logic        is_eot;
        logic        last;

        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        run_status_next = run_status_reg;
        cur_status_next = cur_status_reg;
        delta_next      = delta_reg;
        meta_kind_next  = meta_kind_reg;
        len_next        = len_reg;
        left_next       = left_reg;
        held_next       = held_reg;
        res_valid       = 1'b0;
        res             = '0;
        res.delta_time  = delta_reg;
        do_first        = 1'b0;
        fd_st           = cur_status_reg;
        len_new         = {len_reg[20:0], in_byte[6:0]};
        left_new        = left_reg - 28'd1;
        is_meta         = (cur_status_reg == ST_META);
        is_eot          = is_meta && (meta_kind_reg == META_EOT);
        last            = 1'b0;

        if (in_fire) begin
            unique case (phase_reg)
                PH_HDR: begin
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if (hdr_cnt_reg == 3'd7) begin
                        delta_next = '0;
                        phase_next = PH_DELTA;
                    end
                end
                PH_DELTA: begin
                    delta_next = {delta_reg[20:0], in_byte[6:0]};
                    if (!in_byte[7]) begin
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    priority if (in_byte == ST_META) begin
                        cur_status_next = in_byte;
                        phase_next      = PH_MTYPE;
                    end else if (in_byte == ST_SYSEX || in_byte == ST_SYSEX_ESC) begin
                        cur_status_next = in_byte;
                        meta_kind_next  = '0;
                        len_next        = '0;
                        phase_next      = PH_LEN;
                    end else if (!in_byte[7]) begin
                        cur_status_next = run_status_reg;
                        if (is_chan(run_status_reg)) begin
                            do_first = 1'b1;
                            fd_st    = run_status_reg;
                        end else begin
                            delta_next = {21'd0, in_byte[6:0]};
                        end
                    end else begin
                        run_status_next = in_byte;
                        cur_status_next = in_byte;
                        if (is_chan(in_byte)) begin
                            phase_next = PH_DATA1;
                        end else begin
                            delta_next = '0;
                            phase_next = PH_DELTA;
                        end
                    end
                end
                PH_DATA1: begin
                    do_first = 1'b1;
                    fd_st    = cur_status_reg;
                end
                PH_DATA2: begin
                    res_valid   = 1'b1;
                    res.channel = cur_status_reg[3:0];
                    if (cur_status_reg[7:4] == HI_BEND) begin
                        res.kind         = KIND_BEND;
                        res.second_value = {in_byte[6:0], held_reg[6:0]};
                    end else begin
                        res.kind         = cur_status_reg[7:4] - HI_CHAN_FIRST;
                        res.first_value  = held_reg;
                        res.second_value = {6'd0, in_byte};
                    end
                    delta_next = '0;
                    phase_next = PH_DELTA;
                end
                PH_MTYPE: begin
                    meta_kind_next = in_byte;
                    len_next       = '0;
                    phase_next     = PH_LEN;
                end
                PH_LEN: begin
                    len_next = len_new;
                    if (!in_byte[7]) begin
                        left_next       = len_new;
                        res_valid       = 1'b1;
                        res.kind        = is_meta ? KIND_META : KIND_SYSEX;
                        res.first_value = is_meta ? meta_kind_reg : cur_status_reg;
                        if (len_new == 28'd0) begin
                            res.last_payload = 1'b1;
                            res.end_of_track = is_eot;
                            if (is_eot) begin
                                phase_next      = PH_HDR;
                                hdr_cnt_next    = '0;
                                run_status_next = '0;
                            end else begin
                                delta_next = '0;
                                phase_next = PH_DELTA;
                            end
                        end else begin
                            res.payload_length = len_new;
                            phase_next         = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    left_next          = left_new;
                    last               = (left_new == 28'd0);
                    res_valid          = 1'b1;
                    res.kind           = KIND_PAYLOAD;
                    res.first_value    = in_byte;
                    res.payload_length = len_reg;
                    res.last_payload   = last;
                    res.end_of_track   = last && is_eot;
                    if (last) begin
                        if (is_eot) begin
                            phase_next      = PH_HDR;
                            hdr_cnt_next    = '0;
                            run_status_next = '0;
                        end else begin
                            delta_next = '0;
                            phase_next = PH_DELTA;
                        end
                    end
                end
            endcase

            if (do_first) begin
                if (fd_st[7:4] == HI_PROGRAM || fd_st[7:4] == HI_CHAN_PRES) begin
                    res_valid       = 1'b1;
                    res.kind        = fd_st[7:4] - HI_CHAN_FIRST;
                    res.channel     = fd_st[3:0];
                    res.first_value = in_byte;
                    delta_next      = '0;
                    phase_next      = PH_DELTA;
                end else begin
                    held_next  = in_byte;
                    phase_next = PH_DATA2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HDR;
            hdr_cnt_reg    <= '0;
            run_status_reg <= '0;
            cur_status_reg <= '0;
            delta_reg      <= '0;
            meta_kind_reg  <= '0;
            len_reg        <= '0;
            left_reg       <= '0;
            held_reg       <= '0;
        end else begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            run_status_reg <= run_status_next;
            cur_status_reg <= cur_status_next;
            delta_reg      <= delta_next;
            meta_kind_reg  <= meta_kind_next;
            len_reg        <= len_next;
            left_reg       <= left_next;
            held_reg       <= held_next;
        end
    end

endmodule

FILE: src/mtep_queue.sv
// Result queue between the parser front end and the output channel.
// A small register FIFO; the head entry drives the result ports. Uses mtep_pkg.
`timescale 1ns / 1ps

module mtep_queue
    import mtep_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    head_valid,
    output result_t head_data,
    input  logic    pop_ready
);

    result_t            fifo_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = fifo_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CNT_W'(QUEUE_DEPTH)) |->
        (CNT_W'(PTR_W'(wr_ptr_reg - rd_ptr_reg)) == count_reg))
        else $error("Queue pointers disagree with the entry count.");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("Result pushed into a full queue.");

endmodule

FILE: src/midi_track_event_parser_unit.sv
// Track event parser for standard MIDI file track chunks.
// Instantiates mtep_front and mtep_queue; uses mtep_pkg.
//
// Usage: the input channel (s_valid, s_ready, s_in_byte) carries the raw
// bytes of one track chunk, header included, one byte per transfer. The
// result channel (m_valid, m_ready, m_* fields) carries decoded events:
// channel messages, meta and sysex headers, and one result per payload byte.
// Bytes that complete no event produce no result.
// A result is registered into the result queue when the byte that completes
// it is transferred. Throughput: one byte per cycle while the queue is not full;
// the parser state is updated with each accepted byte.
// A four-entry result queue separates the two channels. When the receiver
// stalls, results collect in the queue and s_ready drops once it is full;
// the parser itself never stalls otherwise.
// Reset (aresetn low, synchronous) empties the queue, clears running status
// and returns the parser to skipping the eight-byte chunk header.
// After an end-of-track meta event the parser again expects a chunk header.
`timescale 1ns / 1ps

module midi_track_event_parser_unit
    import mtep_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic [3:0]  m_channel,
    output logic [27:0] m_delta_time,
    output logic [7:0]  m_first_value,
    output logic [13:0] m_second_value,
    output logic [27:0] m_payload_length,
    output logic        m_last_payload,
    output logic        m_end_of_track
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    logic    queue_full;
    result_t head;

    assign s_ready = !queue_full;
    assign in_fire = s_valid && s_ready;

    mtep_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    mtep_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res),
        .full       (queue_full),
        .head_valid (m_valid),
        .head_data  (head),
        .pop_ready  (m_ready)
    );

    assign m_kind           = head.kind;
    assign m_channel        = head.channel;
    assign m_delta_time     = head.delta_time;
    assign m_first_value    = head.first_value;
    assign m_second_value   = head.second_value;
    assign m_payload_length = head.payload_length;
    assign m_last_payload   = head.last_payload;
    assign m_end_of_track   = head.end_of_track;

endmodule
